// ----- rtl/kid_pkg.sv -----
// Package for the knock interval detector: payload structs, status codes,
// configuration register indexes and reset values.
// No dependencies.
package kid_pkg;

	// Item kinds.
	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_INACTIVE  = 3'd0;
	localparam logic [2:0] ST_LISTEN    = 3'd1;
	localparam logic [2:0] ST_FIRST     = 3'd2;
	localparam logic [2:0] ST_MATCH     = 3'd3;
	localparam logic [2:0] ST_BAD       = 3'd4;
	localparam logic [2:0] ST_TO_SECOND = 3'd5;
	localparam logic [2:0] ST_TO_FIRST  = 3'd6;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_TIMEOUT = 3'd4;

	localparam int unsigned CFG_DATA_W = 24;

	// Register values after reset.
	localparam logic [23:0] RST_THRESHOLD_SQ  = 24'd1039114;
	localparam logic [7:0]  RST_DEBOUNCE      = 8'd2;
	localparam logic [7:0]  RST_WINDOW_LOW    = 8'd5;
	localparam logic [7:0]  RST_WINDOW_HIGH   = 8'd15;
	localparam logic [7:0]  RST_FIRST_TIMEOUT = 8'd100;

	// The session timer holds at this value.
	localparam logic [7:0] TICK_MAX = 8'hFF;

	// One input item: a start request or one tick's raw axis readings.
	typedef struct packed {
		logic              kind;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} kid_in_t;

	// One result item.
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] interval_ticks;
	} kid_out_t;

endpackage

// ----- rtl/knock_interval_detector_core.sv -----
// Knock interval detector top level: input register, knock decision logic,
// session state and result register.
// Depends on kid_pkg.
//
// Usage:
// The item channel (item_valid/item_ready/item) carries either a start
// request or one tick's raw accelerometer reading. Every accepted item gives
// exactly one result on the res channel (res_valid/res_ready/res), in order.
// A start opens a session and answers listening; samples outside a session
// answer inactive and change nothing.
// An item waits in the input register until its result can move on; res_valid
// rises when that result is loaded into the result register.
// Throughput is one item per cycle while res_ready stays high: the decision
// logic between the input register and the result register settles one item
// and updates the session state in the same cycle, so the next item sees the new state right away.
// When the receiver stalls, the result register holds its item and the
// input register fills; item_ready then stays low until res_ready returns.
// The cfg channel is always ready and writes one register per transfer;
// write only while no results are outstanding.
// Reset empties both registers, ends any session and loads the default
// threshold, debounce, window and timeout values.
module knock_interval_detector_core import kid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  kid_in_t               item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output kid_out_t              res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [23:0] threshold_sq_q;
	logic [7:0]  debounce_q;
	logic [7:0]  window_low_q;
	logic [7:0]  window_high_q;
	logic [7:0]  first_timeout_q;

	// Session state.
	logic       session_active_q;
	logic       waiting_second_q;
	logic       prev_above_q;
	logic [7:0] session_ticks_q;
	logic [7:0] last_knock_q;

	// Pipeline registers.
	logic    valid_s1;
	kid_in_t item_s1;
	logic    advance;

	// Decision signals.
	logic signed [11:0] mg_x, mg_y, mg_z;
	logic signed [23:0] sq_x, sq_y, sq_z;
	logic [23:0]        mag_sq;
	logic               above;
	logic [7:0]         dt;
	logic               is_sample;
	logic               knock;
	logic               in_window;
	logic               timeout_second;
	logic               timeout_first;
	logic               done;
	kid_out_t           res_d;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!res_valid || res_ready);
	assign item_ready = !valid_s1 || advance;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_sq_q  <= RST_THRESHOLD_SQ;
			debounce_q      <= RST_DEBOUNCE;
			window_low_q    <= RST_WINDOW_LOW;
			window_high_q   <= RST_WINDOW_HIGH;
			first_timeout_q <= RST_FIRST_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD_SQ:  threshold_sq_q  <= cfg_data[23:0];
				REG_DEBOUNCE:      debounce_q      <= cfg_data[7:0];
				REG_WINDOW_LOW:    window_low_q    <= cfg_data[7:0];
				REG_WINDOW_HIGH:   window_high_q   <= cfg_data[7:0];
				REG_FIRST_TIMEOUT: first_timeout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Squared magnitude in mg squared; each axis in mg is the top 12 bits.
	assign mg_x   = item_s1.accel_x[15:4];
	assign mg_y   = item_s1.accel_y[15:4];
	assign mg_z   = item_s1.accel_z[15:4];
	assign sq_x   = mg_x * mg_x;
	assign sq_y   = mg_y * mg_y;
	assign sq_z   = mg_z * mg_z;
	assign mag_sq = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
	assign above  = mag_sq > threshold_sq_q;

	// Knock and timeout decisions. The last knock never lies after the
	// current tick, so the difference fits in eight bits.
	assign dt        = session_ticks_q - last_knock_q;
	assign is_sample = (item_s1.kind == KIND_SAMPLE) && session_active_q;
	assign knock     = is_sample && above && !prev_above_q && (dt > debounce_q);
	assign in_window = (dt >= window_low_q) && (dt <= window_high_q);
	assign timeout_second = is_sample && !knock && waiting_second_q
		&& (dt > window_high_q);
	assign timeout_first  = is_sample && !knock && !waiting_second_q
		&& (session_ticks_q > first_timeout_q);
	assign done = (knock && waiting_second_q) || timeout_second || timeout_first;

	// Result for the item in the input register.
	always_comb begin
		res_d.status         = ST_INACTIVE;
		res_d.interval_ticks = 8'd0;
		if (item_s1.kind == KIND_START) begin
			res_d.status = ST_LISTEN;
		end else if (session_active_q) begin
			res_d.status = ST_LISTEN;
			if (knock) begin
				res_d.interval_ticks = dt;
				if (!waiting_second_q) begin
					res_d.status = ST_FIRST;
				end else if (in_window) begin
					res_d.status = ST_MATCH;
				end else begin
					res_d.status = ST_BAD;
				end
			end else if (timeout_second) begin
				res_d.status = ST_TO_SECOND;
			end else if (timeout_first) begin
				res_d.status = ST_TO_FIRST;
			end
		end
	end

	// Session state update as the item moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_active_q <= 1'b0;
			waiting_second_q <= 1'b0;
			prev_above_q     <= 1'b0;
			session_ticks_q  <= 8'd0;
			last_knock_q     <= 8'd0;
		end else if (advance) begin
			if (item_s1.kind == KIND_START) begin
				session_active_q <= 1'b1;
				waiting_second_q <= 1'b0;
				prev_above_q     <= 1'b0;
				session_ticks_q  <= 8'd0;
				last_knock_q     <= 8'd0;
			end else if (session_active_q) begin
				if (knock) begin
					last_knock_q <= session_ticks_q;
				end
				if (done) begin
					session_active_q <= 1'b0;
					waiting_second_q <= 1'b0;
				end else begin
					if (knock) begin
						waiting_second_q <= 1'b1;
					end
					prev_above_q <= above;
					if (session_ticks_q != TICK_MAX) begin
						session_ticks_q <= session_ticks_q + 8'd1;
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res <= res_d;
		end
	end

	// A second knock can only be awaited inside a session.
	assert property (@(posedge clk) disable iff (!arst_n)
		waiting_second_q |-> session_active_q)
		else $error("waiting for second knock outside a session");

	// The last knock never lies after the current tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		last_knock_q <= session_ticks_q)
		else $error("last knock tick ahead of session timer");

	// A start always answers listening.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.kind == KIND_START) |=> res.status == ST_LISTEN)
		else $error("start item did not answer listening");

	// Only accepted knocks report an interval.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.interval_ticks != 8'd0) |->
			(res.status == ST_FIRST) || (res.status == ST_MATCH)
			|| (res.status == ST_BAD))
		else $error("interval reported without a knock");

	// An empty input register always takes a new item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input register empty but not ready");

endmodule
